@@ hdl/u8x_pkg.sv @@
package u8x_pkg;

  localparam int CodeW = 21;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_OUTPUT_MODE      = 1'b0,
    REG_REPLACEMENT_CODE = 1'b1
  } reg_index_t;

  localparam logic [CodeW-1:0] ReplacementReset = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_value;
    logic             bad_sequence;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic             output_mode;
    logic [CodeW-1:0] replacement_code;
  } cfg_t;

  // Decoder results for one byte, up to two transactions
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } result_pair_t;

  function automatic logic is_nonchar(input logic [CodeW-1:0] c);
    return (c == 21'h00FFFE) || (c == 21'h00FFFF) ||
           ((c >= 21'h00FDD0) && (c <= 21'h00FDEF));
  endfunction

endpackage

@@ hdl/u8x_decode.sv @@
module u8x_decode
  import u8x_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         accept,
  input  in_item_t     item,
  output result_pair_t results
);

  logic [1:0]       bytes_pending, bytes_pending_next;
  logic             is_three_byte, is_three_byte_next;
  logic [CodeW-1:0] bit_collector, bit_collector_next;
  logic             discarding, discarding_next;

  // Decode one byte against the open sequence
  always_comb begin
    logic [7:0]       b;
    logic             eos;
    logic             bad;
    logic             emit;
    logic [CodeW-1:0] c;
    logic [CodeW-1:0] u;
    b = item.in_byte;
    eos = item.end_of_string;
    bad = 1'b0;
    emit = 1'b0;
    c = '0;
    u = '0;
    bytes_pending_next = bytes_pending;
    is_three_byte_next = is_three_byte;
    bit_collector_next = bit_collector;
    discarding_next = discarding;
    results = '0;

    if (discarding) begin
      if (eos) begin
        discarding_next = 1'b0;
      end
    end else begin
      if (bytes_pending == 2'd0) begin
        priority if (b[7] == 1'b0) begin
          emit = 1'b1;
          c = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
          bit_collector_next = {16'd0, b[4:0]};
          bytes_pending_next = 2'd1;
          is_three_byte_next = 1'b0;
        end else if (b[7:4] == 4'b1110) begin
          bit_collector_next = {17'd0, b[3:0]};
          bytes_pending_next = 2'd2;
          is_three_byte_next = 1'b1;
        end else if (b[7:3] == 5'b11110) begin
          bit_collector_next = {18'd0, b[2:0]};
          bytes_pending_next = 2'd3;
          is_three_byte_next = 1'b0;
        end else begin
          bad = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        bit_collector_next = {bit_collector[CodeW-7:0], b[5:0]};
        bytes_pending_next = bytes_pending - 2'd1;
        if (bytes_pending == 2'd1) begin
          emit = 1'b1;
          c = bit_collector_next;
          if (is_three_byte && is_nonchar(c)) begin
            c = cfg.replacement_code;
          end
          bytes_pending_next = 2'd0;
          is_three_byte_next = 1'b0;
          bit_collector_next = '0;
        end
      end

      if (eos && (bytes_pending_next != 2'd0)) begin
        bad = 1'b1;
      end

      if (bad) begin
        bytes_pending_next = 2'd0;
        is_three_byte_next = 1'b0;
        bit_collector_next = '0;
        discarding_next = !eos;
        results.count = 2'd1;
        results.first = '{code_value: '0, bad_sequence: 1'b1, last_of_run: 1'b1};
      end else begin
        if (eos) begin
          bytes_pending_next = 2'd0;
          is_three_byte_next = 1'b0;
          bit_collector_next = '0;
        end
        // Encode the finished code point
        if (emit) begin
          u = c - 21'h010000;
          priority if (cfg.output_mode) begin
            results.count = 2'd1;
            results.first = '{code_value: c, bad_sequence: 1'b0, last_of_run: 1'b1};
          end else if (c <= 21'h00FFFF) begin
            results.count = 2'd1;
            results.first.code_value = is_nonchar(c) ?
                                       {5'd0, cfg.replacement_code[15:0]} : c;
            results.first.last_of_run = 1'b1;
          end else if (c <= 21'h10FFFF) begin
            results.count = 2'd2;
            results.first.code_value = 21'h00D800 + {11'd0, u[19:10]};
            results.second.code_value = 21'h00DC00 + {11'd0, u[9:0]};
            results.second.last_of_run = 1'b1;
          end else begin
            results.count = 2'd0;
          end
        end
      end
    end
  end

  // Advance sequence state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      is_three_byte <= 1'b0;
      bit_collector <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      is_three_byte <= is_three_byte_next;
      bit_collector <= bit_collector_next;
      discarding <= discarding_next;
    end
  end

endmodule

@@ hdl/u8x_out_buf.sv @@
module u8x_out_buf
  import u8x_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_pair_t results,
  output logic         can_push,
  output logic         out_valid,
  input  logic         out_ready,
  output out_item_t    out_item
);

  logic [1:0] count;
  out_item_t  slot0;
  out_item_t  slot1;
  logic       pop;

  assign pop = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_item = slot0;
  // Take a new byte once all earlier transactions leave by this edge
  assign can_push = (count == 2'd0) || ((count == 2'd1) && out_ready);

  // Hold pending results, shift on each output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= results.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= results.first;
      slot1 <= results.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

@@ hdl/utf8_to_utf16_utf32_transcoder_top.sv @@
// UTF-8 to UTF-16 / UTF-32 stream transcoder.
// Input channel (in_valid/in_ready/in_item) carries one UTF-8 byte per
// transaction with an end_of_string flag. Output channel
// (out_valid/out_ready/out_item) carries code units or code points, an
// error flag for bad or truncated sequences, and last_of_run on the final
// result caused by a byte. A byte may cause zero, one or two results.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 selects
// output mode, 1 the replacement code) at the clock edge; write only idle.
// The first result is registered and appears in the cycle after the input
// transaction. Throughput: one byte per cycle while out_ready is high and
// each byte gives at most one result; a surrogate pair fills the two-entry
// result buffer, so the next byte waits until the buffer drains to one unit.
// Reset (synchronous, active high) clears sequence state, discards pending
// results, and restores UTF-16 mode with replacement code FFFD.
// When the receiver stalls, results stay in the buffer and in_ready drops
// once the buffer cannot take the next byte's results.
module utf8_to_utf16_utf32_transcoder_top
  import u8x_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  reg_index_t       cfg_index,
  input  logic [CodeW-1:0] cfg_data
);

  cfg_t         cfg;
  result_pair_t results;
  logic         accept;

  assign accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_mode <= 1'b0;
      cfg.replacement_code <= ReplacementReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTPUT_MODE:      cfg.output_mode <= cfg_data[0];
        REG_REPLACEMENT_CODE: cfg.replacement_code <= cfg_data;
        default: ;
      endcase
    end
  end

  u8x_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .item    (in_item),
    .results (results)
  );

  u8x_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .results   (results),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
